@@ rtl/cpd_pkg.sv @@
`default_nettype none

package cpd_pkg;

   // stream framing
   localparam int unsigned HeaderBytes  = 16;
   localparam int unsigned TrailerBytes = 4;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // end-of-packet status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_HEADER_CRC = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG   = 3'd2;
   localparam logic [2:0] STATUS_DATA_CRC   = 3'd3;
   localparam logic [2:0] STATUS_ABORTED    = 3'd4;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_PAYLOAD = 2'd1,
      PHASE_TRAILER = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       abort;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] packet_id;
      logic [31:0] record_length;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
   } rsp_item_type;

   // reflected castagnoli crc, one byte
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/cpd_rsp_buf.sv @@
`default_nettype none

module cpd_rsp_buf (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   input  wire cpd_pkg::rsp_item_type push_data,
   output logic                  space_ok,
   output logic                  out_valid,
   input  wire                   out_ready,
   output cpd_pkg::rsp_item_type out_data
);
   import cpd_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   rsp_item_type skid_data_ff, skid_data_in;
   logic         out_fire;

   assign out_fire  = out_valid_ff & out_ready;
   assign space_ok  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push possible while the skid word is held
         if (out_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_fire) begin
         out_valid_in = push_valid;
         out_data_in  = push_data;
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid word only exists behind a waiting output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output is empty");

   // a push against a stalled output must land in the skid stage
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      push_valid && space_ok && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("word pushed during stall was dropped");

   // a stalled output word holds still
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("output word changed while stalled");

endmodule

`default_nettype wire

@@ rtl/crc_checked_packet_deframer.sv @@
// crc_checked_packet_deframer
//
// byte stream deframer for length-prefixed packets guarded by crc32c.
// req channel: one stream byte per word plus an abort flag (read failure or
// end of stream). each packet is a 16-byte header (64-bit id, 32-bit length,
// crc32c of the first 12 bytes, all big-endian), the record bytes, and a
// 4-byte trailer equal to record crc xor header crc.
// rsp channel: at most one word per accepted byte: a header word (id and
// length), a payload word per record byte, or an end word with status.
// csr port: one write-only register, the largest accepted record length.
// output: a result word is registered in the output stage before it shows on rsp.
// throughput: one byte per cycle while req_ready is high; the crc update is
// one unrolled byte step between the state registers, so nothing iterates.
// stall: results go through a two-word output stage, so one byte is still
// taken while a result waits; req_ready drops once both words are full.
// reset: back to header phase, length limit all ones, pending results lost.

`default_nettype none

module crc_checked_packet_deframer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire cpd_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output cpd_pkg::rsp_item_type rsp_data,
   input  wire                   csr_write_enable,
   input  wire [31:0]            csr_write_data
);
   import cpd_pkg::*;

   // framing state
   phase_type   phase_ff, phase_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic [63:0] id_ff, id_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] header_crc_ff, header_crc_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] trailer_ff, trailer_in;
   logic [31:0] max_length_ff;

   logic         req_fire;
   logic         step;           // accepted data byte, no abort
   logic [7:0]   b;
   logic [3:0]   hdr_index;
   logic         in_header;
   logic         header_done;
   logic [31:0]  hdr_crc_field;
   logic         hdr_crc_bad;
   logic         too_long;
   logic [31:0]  crc_step;
   logic [31:0]  pay_count;
   logic         pay_done;
   logic [31:0]  trl_word;
   logic         trl_done;
   logic         data_ok;
   logic         restart;
   logic         res_valid;
   rsp_item_type res_data;
   logic         space_ok;

   assign req_ready = space_ok;
   assign req_fire  = req_valid & space_ok;
   assign step      = req_fire & ~req_data.abort;
   assign b         = req_data.data_byte;

   // per-byte decode
   always_comb begin
      in_header     = (phase_ff != PHASE_PAYLOAD) && (phase_ff != PHASE_TRAILER);
      hdr_index     = byte_count_ff[3:0];
      header_done   = in_header && (hdr_index == 4'(HeaderBytes - 1));
      hdr_crc_field = {header_crc_ff[23:0], b};
      hdr_crc_bad   = (crc_ff ^ CRC_INIT) != hdr_crc_field;
      too_long      = length_ff > max_length_ff;
      crc_step      = crc32c_byte(crc_ff, b);
      pay_count     = byte_count_ff + 32'd1;
      pay_done      = pay_count >= length_ff;
      trl_word      = {trailer_ff[23:0], b};
      trl_done      = byte_count_ff[1:0] == 2'(TrailerBytes - 1);
      data_ok       = (trl_word ^ crc_ff ^ CRC_INIT) == header_crc_ff;
      restart       = req_fire && (req_data.abort
                      || (header_done && (hdr_crc_bad || too_long))
                      || (phase_ff == PHASE_TRAILER && trl_done));
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (restart) begin
         phase_in = PHASE_HEADER;
      end else if (step) begin
         unique case (phase_ff)
            PHASE_PAYLOAD: begin
               if (pay_done) begin
                  phase_in = PHASE_TRAILER;
               end
            end
            PHASE_TRAILER: phase_in = PHASE_TRAILER;
            default: begin
               // header phase; a good header opens the record
               if (header_done) begin
                  phase_in = (length_ff == 32'd0) ? PHASE_TRAILER : PHASE_PAYLOAD;
               end else begin
                  phase_in = PHASE_HEADER;
               end
            end
         endcase
      end
   end

   // datapath registers
   always_comb begin
      byte_count_in = byte_count_ff;
      id_in         = id_ff;
      length_in     = length_ff;
      header_crc_in = header_crc_ff;
      crc_in        = crc_ff;
      trailer_in    = trailer_ff;
      if (step) begin
         unique case (phase_ff)
            PHASE_PAYLOAD: begin
               crc_in        = crc_step;
               byte_count_in = pay_count;
               if (pay_done) begin
                  byte_count_in = 32'd0;
                  trailer_in    = 32'd0;
               end
            end
            PHASE_TRAILER: begin
               trailer_in    = trl_word;
               byte_count_in = byte_count_ff + 32'd1;
            end
            default: begin
               // id bytes, then length bytes, then header crc bytes
               if (hdr_index < 4'd8) begin
                  id_in = {id_ff[55:0], b};
               end else if (hdr_index < 4'd12) begin
                  length_in = {length_ff[23:0], b};
               end else begin
                  header_crc_in = hdr_crc_field;
               end
               if (hdr_index < 4'd12) begin
                  crc_in = crc_step;
               end
               byte_count_in = byte_count_ff + 32'd1;
               if (header_done) begin
                  crc_in        = CRC_INIT;
                  byte_count_in = 32'd0;
                  trailer_in    = 32'd0;
               end
            end
         endcase
      end
      if (restart) begin
         byte_count_in = 32'd0;
         id_in         = 64'd0;
         length_in     = 32'd0;
         header_crc_in = 32'd0;
         crc_in        = CRC_INIT;
         trailer_in    = 32'd0;
      end
   end

   // result word
   always_comb begin
      res_valid = 1'b0;
      res_data  = '0;
      if (req_fire) begin
         if (req_data.abort) begin
            res_valid       = 1'b1;
            res_data.kind   = KIND_END;
            res_data.status = STATUS_ABORTED;
         end else begin
            unique case (phase_ff)
               PHASE_PAYLOAD: begin
                  res_valid             = 1'b1;
                  res_data.kind         = KIND_PAYLOAD;
                  res_data.payload_byte = b;
               end
               PHASE_TRAILER: begin
                  if (trl_done) begin
                     res_valid       = 1'b1;
                     res_data.kind   = KIND_END;
                     res_data.status = data_ok ? STATUS_OK : STATUS_DATA_CRC;
                  end
               end
               default: begin
                  if (header_done) begin
                     res_valid = 1'b1;
                     if (hdr_crc_bad) begin
                        res_data.kind   = KIND_END;
                        res_data.status = STATUS_HEADER_CRC;
                     end else if (too_long) begin
                        res_data.kind   = KIND_END;
                        res_data.status = STATUS_TOO_LONG;
                     end else begin
                        res_data.kind          = KIND_HEADER;
                        res_data.packet_id     = id_ff;
                        res_data.record_length = length_ff;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         byte_count_ff <= 32'd0;
         id_ff         <= 64'd0;
         length_ff     <= 32'd0;
         header_crc_ff <= 32'd0;
         crc_ff        <= CRC_INIT;
         trailer_ff    <= 32'd0;
         max_length_ff <= 32'hFFFF_FFFF;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         header_crc_ff <= header_crc_in;
         crc_ff        <= crc_in;
         trailer_ff    <= trailer_in;
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
      end
   end

   // two-word output stage
   cpd_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res_data),
      .space_ok   (space_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   // byte counters never run past the end of their phase
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_HEADER |-> byte_count_ff < 32'(HeaderBytes))
      else $error("header byte count overran");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_PAYLOAD |-> byte_count_ff < length_ff)
      else $error("payload byte count reached record length");

   a_trailer_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_TRAILER |-> byte_count_ff < 32'(TrailerBytes))
      else $error("trailer byte count overran");

endmodule

`default_nettype wire
